FILE: rtl/core/crc8fr_pkg.sv
// Shared constants, command/status types and the CRC-8 byte update for the frame receiver.
`timescale 1ns / 1ps

package crc8fr_pkg;

    localparam int MAX_PAYLOAD = 64;
    localparam int ADDR_W      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int CNT_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int MSG_LEN_W   = 7;
    localparam int IDX_W       = 6;

    localparam logic [15:0] MAX_LEN       = 16'(MAX_PAYLOAD);
    localparam logic [7:0]  SYNC_FIRST    = 8'hA5;
    localparam logic [7:0]  SYNC_SECOND   = 8'h5A;
    localparam logic [7:0]  FRAME_VERSION = 8'h04;
    localparam logic [7:0]  CRC_POLY      = 8'h07;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic cap_type;
        logic cap_seq;
        logic cap_len_lo;
        logic cap_len_hi;
        logic crc_init;
        logic crc_upd;
        logic store_byte;
        logic rd_clear;
        logic rd_issue;
        logic rd_inc;
        logic out_load;
    } dp_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic len_over;
        logic len_zero_in;
        logic data_done;
        logic crc_match;
        logic rd_last;
        logic out_free;
    } dp_status_t;

    // CRC-8, MSB first, one byte folded in over eight shift steps.
    function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage

FILE: rtl/core/crc8fr_ctrl.sv
// Frame parsing and result sequencing state machine for the frame receiver.
`timescale 1ns / 1ps

module crc8fr_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            rx_byte,
    input  crc8fr_pkg::dp_status_t sts,
    output crc8fr_pkg::dp_cmd_t   cmd
);

    localparam logic [3:0] ST_SYNC0   = 4'd0;
    localparam logic [3:0] ST_SYNC1   = 4'd1;
    localparam logic [3:0] ST_VER     = 4'd2;
    localparam logic [3:0] ST_TYPE    = 4'd3;
    localparam logic [3:0] ST_SEQ     = 4'd4;
    localparam logic [3:0] ST_LENL    = 4'd5;
    localparam logic [3:0] ST_LENH    = 4'd6;
    localparam logic [3:0] ST_DATA    = 4'd7;
    localparam logic [3:0] ST_CHECK   = 4'd8;
    localparam logic [3:0] ST_EMIT_RD = 4'd9;
    localparam logic [3:0] ST_EMIT_LD = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       accept;

    assign s_ready = (state_reg != ST_EMIT_RD) && (state_reg != ST_EMIT_LD);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_SYNC0: begin
                if (accept && (rx_byte == crc8fr_pkg::SYNC_FIRST)) begin
                    state_next = ST_SYNC1;
                end
            end
            ST_SYNC1: begin
                if (accept) begin
                    state_next = (rx_byte == crc8fr_pkg::SYNC_SECOND) ? ST_VER : ST_SYNC0;
                end
            end
            ST_VER: begin
                if (accept) begin
                    if (rx_byte == crc8fr_pkg::FRAME_VERSION) begin
                        cmd.crc_init = 1'b1;
                        state_next   = ST_TYPE;
                    end else begin
                        state_next = ST_SYNC0;
                    end
                end
            end
            ST_TYPE: begin
                if (accept) begin
                    cmd.cap_type = 1'b1;
                    cmd.crc_upd  = 1'b1;
                    state_next   = ST_SEQ;
                end
            end
            ST_SEQ: begin
                if (accept) begin
                    cmd.cap_seq = 1'b1;
                    cmd.crc_upd = 1'b1;
                    state_next  = ST_LENL;
                end
            end
            ST_LENL: begin
                if (accept) begin
                    cmd.cap_len_lo = 1'b1;
                    cmd.crc_upd    = 1'b1;
                    state_next     = ST_LENH;
                end
            end
            ST_LENH: begin
                if (accept) begin
                    cmd.cap_len_hi = 1'b1;
                    cmd.crc_upd    = 1'b1;
                    if (sts.len_over) begin
                        state_next = ST_SYNC0;
                    end else if (sts.len_zero_in) begin
                        state_next = ST_CHECK;
                    end else begin
                        state_next = ST_DATA;
                    end
                end
            end
            ST_DATA: begin
                if (accept) begin
                    cmd.store_byte = 1'b1;
                    cmd.crc_upd    = 1'b1;
                    if (sts.data_done) begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (accept) begin
                    if (sts.crc_match) begin
                        cmd.rd_clear = 1'b1;
                        state_next   = ST_EMIT_RD;
                    end else begin
                        state_next = ST_SYNC0;
                    end
                end
            end
            ST_EMIT_RD: begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_EMIT_LD;
            end
            ST_EMIT_LD: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    if (sts.rd_last) begin
                        state_next = ST_SYNC0;
                    end else begin
                        cmd.rd_inc = 1'b1;
                        state_next = ST_EMIT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_SYNC0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_SYNC0;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/core/crc8fr_dp.sv
// Header registers, running CRC, payload buffer and output register of the frame receiver.
`timescale 1ns / 1ps

module crc8fr_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [7:0]                          rx_byte,
    input  crc8fr_pkg::dp_cmd_t                 cmd,
    output crc8fr_pkg::dp_status_t              sts,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [7:0]                          m_frame_type,
    output logic [7:0]                          m_msg_seq,
    output logic [crc8fr_pkg::MSG_LEN_W-1:0]    m_msg_length,
    output logic [crc8fr_pkg::IDX_W-1:0]        m_byte_index,
    output logic [7:0]                          m_data_byte,
    output logic                                m_has_byte,
    output logic                                m_last
);

    localparam int ADDR_W = crc8fr_pkg::ADDR_W;
    localparam int CNT_W  = crc8fr_pkg::CNT_W;

    logic [7:0]        type_reg;
    logic [7:0]        seq_reg;
    logic [7:0]        len_lo_reg;
    logic [CNT_W-1:0]  len_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [7:0]        crc_reg;
    logic [ADDR_W-1:0] rd_idx_reg;
    logic [7:0]        rd_data_reg;
    logic [7:0]        mem [crc8fr_pkg::MAX_PAYLOAD];

    logic                                 out_valid_reg;
    logic [7:0]                           out_type_reg;
    logic [7:0]                           out_seq_reg;
    logic [crc8fr_pkg::MSG_LEN_W-1:0]     out_len_reg;
    logic [crc8fr_pkg::IDX_W-1:0]         out_idx_reg;
    logic [7:0]                           out_data_reg;
    logic                                 out_has_reg;
    logic                                 out_last_reg;

    logic [15:0]       len_full;
    logic [CNT_W-1:0]  cnt_inc;
    logic [CNT_W-1:0]  rd_inc;
    logic              len_zero;

    assign len_full = {rx_byte, len_lo_reg};
    assign cnt_inc  = cnt_reg + CNT_W'(1);
    assign rd_inc   = CNT_W'(rd_idx_reg) + CNT_W'(1);
    assign len_zero = (len_reg == '0);

    assign sts.len_over    = (len_full > crc8fr_pkg::MAX_LEN);
    assign sts.len_zero_in = (len_full == 16'd0);
    assign sts.data_done   = (cnt_inc >= len_reg);
    assign sts.crc_match   = (rx_byte == crc_reg);
    assign sts.rd_last     = len_zero || (rd_inc == len_reg);
    assign sts.out_free    = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (cmd.cap_type) begin
            type_reg <= rx_byte;
        end
        if (cmd.cap_seq) begin
            seq_reg <= rx_byte;
        end
        if (cmd.cap_len_lo) begin
            len_lo_reg <= rx_byte;
        end
        if (cmd.cap_len_hi) begin
            len_reg <= len_full[CNT_W-1:0];
            cnt_reg <= '0;
        end else if (cmd.store_byte) begin
            cnt_reg <= cnt_inc;
        end
        if (cmd.crc_init) begin
            crc_reg <= crc8fr_pkg::crc_feed(8'h00, rx_byte);
        end else if (cmd.crc_upd) begin
            crc_reg <= crc8fr_pkg::crc_feed(crc_reg, rx_byte);
        end
        if (cmd.rd_clear) begin
            rd_idx_reg <= '0;
        end else if (cmd.rd_inc) begin
            rd_idx_reg <= rd_idx_reg + ADDR_W'(1);
        end
    end

    // Payload buffer: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (cmd.store_byte) begin
            mem[cnt_reg[ADDR_W-1:0]] <= rx_byte;
        end
        if (cmd.rd_issue) begin
            rd_data_reg <= mem[rd_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_type_reg <= type_reg;
            out_seq_reg  <= seq_reg;
            out_len_reg  <= crc8fr_pkg::MSG_LEN_W'(len_reg);
            out_idx_reg  <= len_zero ? '0 : crc8fr_pkg::IDX_W'(rd_idx_reg);
            out_data_reg <= len_zero ? 8'h00 : rd_data_reg;
            out_has_reg  <= !len_zero;
            out_last_reg <= sts.rd_last;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_frame_type = out_type_reg;
    assign m_msg_seq    = out_seq_reg;
    assign m_msg_length = out_len_reg;
    assign m_byte_index = out_idx_reg;
    assign m_data_byte  = out_data_reg;
    assign m_has_byte   = out_has_reg;
    assign m_last       = out_last_reg;

endmodule

FILE: rtl/core/crc8_frame_receiver.sv
// Top level of the sync/length/CRC-8 frame receiver.
`timescale 1ns / 1ps

// The receiver takes one received byte per input beat and hunts for the sync pair 0xA5 0x5A,
// followed by version 0x04, a type byte, a sequence byte and a little-endian 16-bit length.
// Frames longer than 64 payload bytes are dropped and the hunt starts again. Payload bytes are
// stored in a 64-entry buffer while a CRC-8 (polynomial 0x07, initial value zero, MSB first)
// runs over everything from the version byte to the last payload byte. When the byte after
// the payload equals that CRC, the frame is played out as one result beat per payload byte,
// with last set on the final one, or as a single beat with has_byte low when the length is
// zero; a frame that fails the check produces nothing. While parsing, s_ready is high and one
// byte is taken every clock cycle in which s_valid is high. After a good frame the input is
// held off until the last result is loaded: each result is a registered buffer read followed
// by a load of the output register, and that load waits while the output register still
// holds an earlier beat that m_ready has not taken. The output register decouples the sides,
// so the next frame's bytes may be taken while its final result still waits for the consumer.
// No clearing pass is needed after reset.

module crc8_frame_receiver (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_rx_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [7:0]                       m_frame_type,
    output logic [7:0]                       m_msg_seq,
    output logic [crc8fr_pkg::MSG_LEN_W-1:0] m_msg_length,
    output logic [crc8fr_pkg::IDX_W-1:0]     m_byte_index,
    output logic [7:0]                       m_data_byte,
    output logic                             m_has_byte,
    output logic                             m_last
);

    crc8fr_pkg::dp_cmd_t    cmd;
    crc8fr_pkg::dp_status_t sts;

    // The controller walks the frame fields and sequences the result read-out.
    crc8fr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .rx_byte (s_rx_data),
        .sts     (sts),
        .cmd     (cmd)
    );

    // The datapath holds the header fields, CRC, payload buffer and output register.
    crc8fr_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .rx_byte      (s_rx_data),
        .cmd          (cmd),
        .sts          (sts),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_frame_type (m_frame_type),
        .m_msg_seq    (m_msg_seq),
        .m_msg_length (m_msg_length),
        .m_byte_index (m_byte_index),
        .m_data_byte  (m_data_byte),
        .m_has_byte   (m_has_byte),
        .m_last       (m_last)
    );

`ifndef SYNTH
    // An empty-frame beat is always the only and final beat, with a cleared byte.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_has_byte) |-> (m_last && (m_byte_index == '0) && (m_data_byte == 8'h00)))
        else $error("empty-frame result beat is malformed");

    // A payload beat always lies inside the frame's length.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_has_byte) |-> (7'(m_byte_index) < m_msg_length))
        else $error("payload beat index beyond frame length");

    // The output register is only reloaded when its previous beat is gone or leaving.
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid || m_ready))
        else $error("output register overwritten while holding a beat");

    // No input byte is taken while results are being read out.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.out_load || cmd.rd_issue) |-> !s_ready)
        else $error("input accepted during result read-out");
`endif

endmodule
